// ----- src/sorted_table_insert_search_unit_assert.svh -----
// Assertion macros used by the checker of the sorted table unit.
`ifndef SORTED_TABLE_INSERT_SEARCH_UNIT_ASSERT_SVH
`define SORTED_TABLE_INSERT_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define STIS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted table unit check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define STIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted table unit check failed");

`endif

// ----- src/stis_pkg.sv -----
// Types and constants shared by the sorted table insert and search unit.
package stis_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned KEY_WIDTH = 32;
  localparam int unsigned COUNT_W   = $clog2(DEPTH + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    op_e                          operation;
    logic signed [KEY_WIDTH-1:0]  key;
  } in_word_t;

  typedef struct packed {
    status_e              status;
    logic [COUNT_W-1:0]   entry_total;
  } out_word_t;

  typedef struct packed {
    logic ins;
    logic valid;
    logic tail;
  } cell_ctl_t;

endpackage

// ----- src/stis_cell.sv -----
// One cell of the sorted key row: holds a key, compares it and shifts on insert.
module stis_cell (
  input  logic                                  clk_i,
  input  stis_pkg::cell_ctl_t                   ctl_i,
  input  logic signed [stis_pkg::KEY_WIDTH-1:0] key_i,
  input  logic signed [stis_pkg::KEY_WIDTH-1:0] left_key_i,
  input  logic                                  left_ge_i,
  output logic signed [stis_pkg::KEY_WIDTH-1:0] key_o,
  output logic                                  ge_o,
  output logic                                  hit_o
);
  import stis_pkg::*;

  logic signed [KEY_WIDTH-1:0] key_q;
  logic signed [KEY_WIDTH-1:0] key_d;
  logic                        write;

  assign ge_o  = ctl_i.valid && (key_q >= key_i);
  assign hit_o = ctl_i.valid && (key_q == key_i);
  assign write = ctl_i.ins && (ctl_i.tail || ge_o);
  assign key_d = left_ge_i ? left_key_i : key_i;
  assign key_o = key_q;

  always_ff @(posedge clk_i) begin
    if (write) begin
      key_q <= key_d;
    end
  end

endmodule

// ----- src/sorted_table_insert_search_unit.sv -----
// Sorted key table: a row of cells keeps signed keys in ascending order. Each
// cell compares its key with the incoming word's key in the same cycle; on an
// insert the new key lands in the first cell whose key is not below it (or the
// tail) and each later cell up to the tail takes its left neighbour's key.
// One word per cycle is accepted unless stalled; its result is in the output
// register in the cycle after acceptance. The only stall is a result held in
// the output register while out_ready_i is low. No clearing pass follows reset.
module sorted_table_insert_search_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  stis_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output stis_pkg::out_word_t out_word_o
);
  import stis_pkg::*;

  logic [COUNT_W-1:0]          count_q, count_d;
  logic                        out_valid_q, out_valid_d;
  out_word_t                   out_word_q, out_word_d;
  logic                        accept;
  logic                        full;
  logic                        do_ins;
  logic                        hit;
  cell_ctl_t                   ctl   [DEPTH];
  logic signed [KEY_WIDTH-1:0] keys  [DEPTH];
  logic                        ge    [DEPTH];
  logic [DEPTH-1:0]            hits;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == COUNT_W'(DEPTH));
  assign do_ins     = accept && (in_word_i.operation == OP_INSERT) && !full;
  assign hit        = |hits;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctl[i].ins   = do_ins;
    assign ctl[i].valid = (COUNT_W'(i) < count_q);
    assign ctl[i].tail  = (COUNT_W'(i) == count_q);

    if (i == 0) begin : g_first
      stis_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (ctl[i]),
        .key_i      (in_word_i.key),
        .left_key_i (in_word_i.key),
        .left_ge_i  (1'b0),
        .key_o      (keys[i]),
        .ge_o       (ge[i]),
        .hit_o      (hits[i])
      );
    end else begin : g_rest
      stis_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (ctl[i]),
        .key_i      (in_word_i.key),
        .left_key_i (keys[i-1]),
        .left_ge_i  (ge[i-1]),
        .key_o      (keys[i]),
        .ge_o       (ge[i]),
        .hit_o      (hits[i])
      );
    end
  end

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      if (do_ins) begin
        count_d = count_q + COUNT_W'(1);
      end
      unique case (in_word_i.operation)
        OP_INSERT: out_word_d.status = full ? ST_FULL : ST_INSERTED;
        OP_LOOKUP: out_word_d.status = hit ? ST_FOUND : ST_NOT_FOUND;
        default:   out_word_d.status = ST_NOT_FOUND;
      endcase
      out_word_d.entry_total = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- src/stis_checker.sv -----
// Port-level checker for the sorted table unit and its bind statement.
`include "sorted_table_insert_search_unit_assert.svh"

module stis_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input stis_pkg::out_word_t out_word_o
);
  import stis_pkg::*;

  `STIS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word_o))
  `STIS_ASSERT_IMPLY(a_ready_when_empty, !out_valid_o, in_ready_o)
  `STIS_ASSERT_IMPLY(a_total_bound, out_valid_o, out_word_o.entry_total <= COUNT_W'(DEPTH))
  `STIS_ASSERT_IMPLY(a_full_total, out_valid_o && (out_word_o.status == ST_FULL), out_word_o.entry_total == COUNT_W'(DEPTH))
  `STIS_ASSERT_IMPLY(a_insert_total, out_valid_o && (out_word_o.status == ST_INSERTED), out_word_o.entry_total != '0)

endmodule

bind sorted_table_insert_search_unit stis_checker u_stis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
